FILE: hw/rtl/cvh_pkg.sv
// ----------------------------------------------------------------------------
// cvh_pkg
// shared types and constants of the binary image convex hull unit
// ----------------------------------------------------------------------------
package cvh_pkg;

	// configuration register width and index codes
	localparam int REG_W = 7;
	localparam int OUT_W = 6;

	// largest image side, tied to the coordinate width of the outputs
	localparam int MAX_SIDE = 64;

	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	typedef logic [REG_W-1:0] cfg_reg_t;
	typedef logic [OUT_W-1:0] out_coord_t;

endpackage

FILE: hw/rtl/cvh_mul.sv
// ----------------------------------------------------------------------------
// cvh_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module cvh_mul #(
	parameter int W = 7
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

FILE: hw/rtl/cvh_pmem.sv
// ----------------------------------------------------------------------------
// cvh_pmem
// point store: one write port, one registered read port
// ----------------------------------------------------------------------------
module cvh_pmem #(
	parameter int DEPTH = 4096,
	parameter int DW    = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/binary_image_convex_hull_unit.sv
// ----------------------------------------------------------------------------
// binary_image_convex_hull_unit
// convex hull of a binary image by gift wrapping over a stored point list
// ----------------------------------------------------------------------------
// Pixels enter one beat per cycle in raster order while the unit is loading
// and cfg_we is low; each object pixel's column and row go to the point
// store while it has room. After the last pixel of the image the input
// stalls and a gift wrap runs: every wrap step scans all stored points
// through the single shared multiplier, each point with one store read and
// one difference and, if not yet used, four products and one decision. The
// vertices then leave on the output channel, each beat held through any
// output stall, bottom point first, the final beat flagged last_vertex.
// An empty image gives a single no_object beat. A configuration write
// while loading restarts the image.
module binary_image_convex_hull_unit
	import cvh_pkg::*;
#(
	parameter int MAX_POINTS = 4096,
	parameter int MAX_HULL   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  cfg_reg_t   cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       pixel_set,
	output logic       out_valid,
	input  logic       out_stall,
	output out_coord_t hull_x,
	output out_coord_t hull_y,
	output logic       last_vertex,
	output logic       no_object,
	output logic       overflow
);

	// widths that follow from the parameters
	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int PW = $clog2(MAX_POINTS);
	localparam int HW = $clog2(MAX_HULL);
	localparam int HCW = $clog2(MAX_HULL + 1);
	localparam int DW = CW + 1;
	localparam int PDW = 2 * DW;
	localparam int AW = PDW + 1;
	localparam int MW = 2 * CW + 1;

	// sequencer codes
	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_WINIT  = 4'd1;
	localparam logic [3:0] S_WCHK   = 4'd2;
	localparam logic [3:0] S_CRD    = 4'd3;
	localparam logic [3:0] S_CDIF   = 4'd4;
	localparam logic [3:0] S_M0     = 4'd5;
	localparam logic [3:0] S_M1     = 4'd6;
	localparam logic [3:0] S_M2     = 4'd7;
	localparam logic [3:0] S_M3     = 4'd8;
	localparam logic [3:0] S_DEC    = 4'd9;
	localparam logic [3:0] S_STEP   = 4'd10;
	localparam logic [3:0] S_ERD    = 4'd11;
	localparam logic [3:0] S_ELD    = 4'd12;
	localparam logic [3:0] S_EWT    = 4'd13;
	localparam logic [3:0] S_EEMPTY = 4'd14;

	logic [3:0] state_q;

	// configuration and effective image size
	cfg_reg_t width_q, height_q;
	logic [SW-1:0] eff_w, eff_h;

	always_comb begin
		if (width_q == '0) eff_w = SW'(1);
		else if (int'(width_q) > MAX_SIDE) eff_w = SW'(MAX_SIDE);
		else eff_w = SW'(width_q);
		if (height_q == '0) eff_h = SW'(1);
		else if (int'(height_q) > MAX_SIDE) eff_h = SW'(MAX_SIDE);
		else eff_h = SW'(height_q);
	end

	// raster position and point bookkeeping
	logic [CW-1:0] x_q, y_q;
	logic [PW:0]   cnt_q;
	logic [PW-1:0] bot_idx_q, top_idx_q;
	logic [CW-1:0] bot_x_q, bot_y_q, top_y_q;

	logic in_acc, last_pix, store_ok;
	// a configuration write holds the pixel beat back
	assign in_stall = (state_q != S_LOAD) || cfg_we;
	assign in_acc   = in_valid && !in_stall;
	assign last_pix = (SW'(x_q) == eff_w - SW'(1)) && (SW'(y_q) == eff_h - SW'(1));
	assign store_ok = cnt_q < (PW + 1)'(MAX_POINTS);

	// wrap state: current point, scan index, best candidate
	logic [CW-1:0]        px_q, py_q;
	logic [PW-1:0]        pidx_q, scan_q, best_idx_q;
	logic [CW-1:0]        bx_q, by_q;
	logic signed [DW-1:0] x1_q, y1_q, bx2_q, by2_q;
	logic signed [PDW-1:0] p0_q, sq_q;
	logic signed [AW-1:0]  cross_q, bdist_q;
	logic                  found_q, chain_q;
	logic [CW-1:0]         cx_q, cy_q;

	// point store
	logic          pm_we;
	logic [PW-1:0] pm_waddr;
	logic [MW-1:0] pm_wdata, pm_rdata;

	always_comb begin
		if (state_q == S_STEP) begin
			pm_we    = found_q;
			pm_waddr = best_idx_q;
			pm_wdata = {1'b1, by_q, bx_q};
		end else begin
			pm_we    = in_acc && pixel_set && store_ok;
			pm_waddr = cnt_q[PW-1:0];
			pm_wdata = {1'b0, y_q, x_q};
		end
	end

	cvh_pmem #(
		.DEPTH (MAX_POINTS),
		.DW    (MW)
	) u_pmem (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (scan_q),
		.rdata (pm_rdata)
	);

	logic          rd_used;
	logic [CW-1:0] rd_x, rd_y;
	assign rd_used = pm_rdata[MW-1];
	assign rd_y    = pm_rdata[2*CW-1:CW];
	assign rd_x    = pm_rdata[CW-1:0];

	// shared multiplier, operands picked by the sequencer
	logic signed [DW-1:0]  mul_a, mul_b;
	logic signed [PDW-1:0] mul_p;

	always_comb begin
		unique case (state_q)
			S_M0:    begin mul_a = x1_q;  mul_b = by2_q; end
			S_M1:    begin mul_a = bx2_q; mul_b = y1_q;  end
			S_M2:    begin mul_a = x1_q;  mul_b = x1_q;  end
			default: begin mul_a = y1_q;  mul_b = y1_q;  end
		endcase
	end

	cvh_mul #(
		.W (DW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// candidate decision: cross sign first, distance on a tie
	logic signed [AW-1:0] cand_dist;
	logic                 take;
	assign cand_dist = AW'(sq_q) + AW'(mul_p);
	assign take = !found_q || (cross_q > 0) || ((cross_q == 0) && (cand_dist > bdist_q));

	logic scan_end;
	assign scan_end = ((PW + 1)'(scan_q) == cnt_q - (PW + 1)'(1));

	// hull store, kept as coordinates
	logic [2*CW-1:0] hmem [MAX_HULL];
	logic [2*CW-1:0] h_rdata;
	logic [HCW-1:0]  hcnt_q, ek_q;
	logic            cut_q;
	logic            h_push, h_we;
	logic [HW-1:0]   h_waddr;
	logic [CW-1:0]   h_px, h_py;

	always_comb begin
		h_push  = 1'b0;
		h_we    = 1'b0;
		h_waddr = hcnt_q[HW-1:0];
		h_px    = bx_q;
		h_py    = by_q;
		if (state_q == S_WINIT) begin
			// bottom point always lands in the first entry
			h_we    = 1'b1;
			h_waddr = '0;
			h_px    = bot_x_q;
			h_py    = bot_y_q;
		end else if (state_q == S_STEP && found_q) begin
			h_push = !chain_q || (best_idx_q != bot_idx_q);
			h_we   = h_push && (hcnt_q < HCW'(MAX_HULL));
		end
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hmem[h_waddr] <= {h_py, h_px};
		end
		h_rdata <= hmem[ek_q[HW-1:0]];
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			width_q     <= 7'd64;
			height_q    <= 7'd64;
			x_q         <= '0;
			y_q         <= '0;
			cnt_q       <= '0;
			bot_idx_q   <= '0;
			top_idx_q   <= '0;
			bot_x_q     <= '0;
			bot_y_q     <= '0;
			top_y_q     <= '0;
			px_q        <= '0;
			py_q        <= '0;
			pidx_q      <= '0;
			scan_q      <= '0;
			best_idx_q  <= '0;
			bx_q        <= '0;
			by_q        <= '0;
			x1_q        <= '0;
			y1_q        <= '0;
			bx2_q       <= '0;
			by2_q       <= '0;
			p0_q        <= '0;
			sq_q        <= '0;
			cross_q     <= '0;
			bdist_q     <= '0;
			found_q     <= 1'b0;
			chain_q     <= 1'b0;
			cx_q        <= '0;
			cy_q        <= '0;
			hcnt_q      <= '0;
			ek_q        <= '0;
			cut_q       <= 1'b0;
			out_valid   <= 1'b0;
			hull_x      <= '0;
			hull_y      <= '0;
			last_vertex <= 1'b0;
			no_object   <= 1'b0;
			overflow    <= 1'b0;
		end else begin
			if (h_push) begin
				if (hcnt_q < HCW'(MAX_HULL)) hcnt_q <= hcnt_q + HCW'(1);
				else cut_q <= 1'b1;
			end
			unique case (state_q)
				S_LOAD: begin
					if (cfg_we) begin
						// any write restarts the image
						if (cfg_index == CFG_IDX_WIDTH) width_q <= cfg_data;
						else height_q <= cfg_data;
						x_q   <= '0;
						y_q   <= '0;
						cnt_q <= '0;
					end else if (in_acc) begin
						if (pixel_set && store_ok) begin
							if (cnt_q == '0) begin
								bot_idx_q <= '0;
								top_idx_q <= '0;
								bot_x_q   <= x_q;
								bot_y_q   <= y_q;
								top_y_q   <= y_q;
							end else begin
								// rightmost of the lowest row, leftmost of the highest
								if (y_q <= bot_y_q) begin
									bot_idx_q <= cnt_q[PW-1:0];
									bot_x_q   <= x_q;
									bot_y_q   <= y_q;
								end
								if (y_q > top_y_q) begin
									top_idx_q <= cnt_q[PW-1:0];
									top_y_q   <= y_q;
								end
							end
							cnt_q <= cnt_q + (PW + 1)'(1);
						end
						if (last_pix) begin
							x_q <= '0;
							y_q <= '0;
							if (cnt_q == '0 && !pixel_set) state_q <= S_EEMPTY;
							else state_q <= S_WINIT;
						end else if (SW'(x_q) == eff_w - SW'(1)) begin
							x_q <= '0;
							y_q <= y_q + CW'(1);
						end else begin
							x_q <= x_q + CW'(1);
						end
					end
				end
				S_WINIT: begin
					// bottom point opens the hull in the first entry
					hcnt_q  <= HCW'(1);
					cut_q   <= 1'b0;
					px_q    <= bot_x_q;
					py_q    <= bot_y_q;
					pidx_q  <= bot_idx_q;
					chain_q <= 1'b0;
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					scan_q  <= '0;
					found_q <= 1'b0;
					if (!chain_q) begin
						if (pidx_q == top_idx_q) begin
							chain_q <= 1'b1;
							if (pidx_q == bot_idx_q) begin
								ek_q    <= '0;
								state_q <= S_ERD;
							end else begin
								state_q <= S_CRD;
							end
						end else begin
							state_q <= S_CRD;
						end
					end else if (pidx_q == bot_idx_q) begin
						ek_q    <= '0;
						state_q <= S_ERD;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CDIF;
				end
				S_CDIF: begin
					cx_q <= rd_x;
					cy_q <= rd_y;
					x1_q <= DW'(rd_x) - DW'(px_q);
					y1_q <= DW'(rd_y) - DW'(py_q);
					if (rd_used) begin
						if (scan_end) state_q <= S_STEP;
						else begin
							scan_q  <= scan_q + PW'(1);
							state_q <= S_CRD;
						end
					end else begin
						state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: begin
					p0_q    <= mul_p;
					state_q <= S_M2;
				end
				S_M2: begin
					cross_q <= AW'(p0_q) - AW'(mul_p);
					state_q <= S_M3;
				end
				S_M3: begin
					sq_q    <= mul_p;
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (take) begin
						found_q    <= 1'b1;
						best_idx_q <= scan_q;
						bx_q       <= cx_q;
						by_q       <= cy_q;
						bx2_q      <= x1_q;
						by2_q      <= y1_q;
						bdist_q    <= cand_dist;
					end
					if (scan_end) state_q <= S_STEP;
					else begin
						scan_q  <= scan_q + PW'(1);
						state_q <= S_CRD;
					end
				end
				S_STEP: begin
					// mark the pick used and move on, or stop when none is left
					if (found_q) begin
						px_q    <= bx_q;
						py_q    <= by_q;
						pidx_q  <= best_idx_q;
						state_q <= S_WCHK;
					end else begin
						ek_q    <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_ELD;
				S_ELD: begin
					out_valid   <= 1'b1;
					hull_x      <= OUT_W'(h_rdata[CW-1:0]);
					hull_y      <= OUT_W'(h_rdata[2*CW-1:CW]);
					last_vertex <= (ek_q + HCW'(1) == hcnt_q);
					no_object   <= 1'b0;
					overflow    <= cut_q;
					state_q     <= S_EWT;
				end
				S_EEMPTY: begin
					out_valid   <= 1'b1;
					hull_x      <= '0;
					hull_y      <= '0;
					last_vertex <= 1'b1;
					no_object   <= 1'b1;
					overflow    <= 1'b0;
					state_q     <= S_EWT;
				end
				S_EWT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last_vertex) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							ek_q    <= ek_q + HCW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// no new pixel is taken while a result beat is pending
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("pixel accepted during hull output");

	// the hull store never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n) hcnt_q <= HCW'(MAX_HULL))
		else $error("hull count beyond depth");

	// an empty-image beat is the only and last beat of its run
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_object) |-> (last_vertex && !overflow))
		else $error("malformed no-object beat");

	// the last pixel of an image hands over to the wrap or the empty beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_pix && !cfg_we) |=> in_stall)
		else $error("input not stalled after last pixel");

endmodule

FILE: bench/cvh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvh_checker
// watches the pixel, configuration and hull channels and checks every vertex
// ----------------------------------------------------------------------------
// Keeps its own copy of the image size and the point list, wraps the hull
// on the final pixel of each image and compares each output beat in order.
// ----------------------------------------------------------------------------
module cvh_checker
	import cvh_pkg::*;
#(
	parameter int MAX_POINTS = 4096,
	parameter int MAX_HULL   = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  cfg_reg_t   cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       pixel_set,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_coord_t hull_x,
	input  out_coord_t hull_y,
	input  logic       last_vertex,
	input  logic       no_object,
	input  logic       overflow,
	output int         errors,
	output int         pending,
	output int         vertices_seen
);

	typedef struct packed {
		out_coord_t x;
		out_coord_t y;
		logic       last;
		logic       empty;
		logic       cut;
	} vertex_t;

	vertex_t    hull_expect_q[$];
	cfg_reg_t   width_reg, height_reg;
	int         pt_x[MAX_POINTS];
	int         pt_y[MAX_POINTS];
	bit         pt_used[MAX_POINTS];
	int         n_points, n_pixels, bottom_idx, top_idx;
	int         hull_idx[MAX_HULL];
	int         n_hull;
	bit         hull_cut;

	assign pending = hull_expect_q.size();

	function automatic int clamp_side(cfg_reg_t v);
		if (v == 0)
			return 1;
		if (int'(v) > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	// candidate c wins over incumbent b as seen from p
	function automatic bit turns_outer(int p, int c, int b);
		longint x1, y1, x2, y2, d;
		x1 = pt_x[c] - pt_x[p];
		y1 = pt_y[c] - pt_y[p];
		x2 = pt_x[b] - pt_x[p];
		y2 = pt_y[b] - pt_y[p];
		d = x1 * y2 - x2 * y1;
		if (d != 0)
			return d > 0;
		return (x1 * x1 + y1 * y1) > (x2 * x2 + y2 * y2);
	endfunction

	function automatic int pick_next(int p);
		int best;
		best = -1;
		for (int i = 0; i < n_points; i++) begin
			if (!pt_used[i] && (best < 0 || turns_outer(p, i, best)))
				best = i;
		end
		return best;
	endfunction

	function automatic void add_vertex(int idx);
		if (n_hull < MAX_HULL) begin
			hull_idx[n_hull] = idx;
			n_hull++;
		end else
			hull_cut = 1'b1;
	endfunction

	function automatic void wrap_points();
		int p, q;
		p = bottom_idx;
		n_hull = 0;
		hull_cut = 1'b0;
		add_vertex(p);
		while (p != top_idx) begin
			q = pick_next(p);
			if (q < 0)
				return;
			pt_used[q] = 1'b1;
			p = q;
			add_vertex(p);
		end
		while (p != bottom_idx) begin
			q = pick_next(p);
			if (q < 0)
				return;
			pt_used[q] = 1'b1;
			p = q;
			if (p != bottom_idx)
				add_vertex(p);
		end
	endfunction

	function automatic void clear_image();
		n_points = 0;
		n_pixels = 0;
		bottom_idx = 0;
		top_idx = 0;
	endfunction

	function automatic void take_pixel(logic set);
		int w, h, x, y;
		vertex_t v;
		w = clamp_side(width_reg);
		h = clamp_side(height_reg);
		if (n_pixels >= w * h)
			clear_image();
		x = n_pixels % w;
		y = n_pixels / w;
		if (set && n_points < MAX_POINTS) begin
			pt_x[n_points] = x;
			pt_y[n_points] = y;
			pt_used[n_points] = 1'b0;
			if (n_points == 0) begin
				bottom_idx = 0;
				top_idx = 0;
			end else begin
				if (y <= pt_y[bottom_idx])
					bottom_idx = n_points;
				if (y > pt_y[top_idx])
					top_idx = n_points;
			end
			n_points++;
		end
		n_pixels++;
		if (n_pixels < w * h)
			return;
		if (n_points == 0) begin
			v = '{x: '0, y: '0, last: 1'b1, empty: 1'b1, cut: 1'b0};
			hull_expect_q.push_back(v);
		end else begin
			wrap_points();
			for (int k = 0; k < n_hull; k++) begin
				v.x = out_coord_t'(pt_x[hull_idx[k]]);
				v.y = out_coord_t'(pt_y[hull_idx[k]]);
				v.last = (k + 1 == n_hull);
				v.empty = 1'b0;
				v.cut = hull_cut;
				hull_expect_q.push_back(v);
			end
		end
		clear_image();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_t exp_v, got_v;
		if (!arst_n) begin
			width_reg = cfg_reg_t'(64);
			height_reg = cfg_reg_t'(64);
			clear_image();
			hull_expect_q.delete();
			errors <= 0;
			vertices_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_IDX_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
				clear_image();
			end
			if (in_valid && !in_stall)
				take_pixel(pixel_set);
			if (out_valid && !out_stall) begin
				got_v = '{x: hull_x, y: hull_y, last: last_vertex, empty: no_object,
					cut: overflow};
				vertices_seen <= vertices_seen + 1;
				if (hull_expect_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected vertex beat x=%0d y=%0d", $realtime,
							hull_x, hull_y);
					errors <= errors + 1;
				end else begin
					exp_v = hull_expect_q.pop_front();
					if (exp_v != got_v) begin
						if (errors < 10)
							$display("%0t: vertex mismatch exp x=%0d y=%0d l=%0b e=%0b c=%0b",
								$realtime, exp_v.x, exp_v.y, exp_v.last, exp_v.empty,
								exp_v.cut, " got x=%0d y=%0d l=%0b e=%0b c=%0b",
								got_v.x, got_v.y, got_v.last, got_v.empty, got_v.cut);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the binary image convex hull unit
// ----------------------------------------------------------------------------
// Streams images of many sizes: directed corner cases, then random empty,
// full, noise, blob, row-0 and sparse ones; the checker predicts each vertex.
// ----------------------------------------------------------------------------
module testbench;
	import cvh_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	cfg_reg_t   cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       pixel_set;
	logic       out_valid;
	logic       out_stall;
	out_coord_t hull_x;
	out_coord_t hull_y;
	logic       last_vertex;
	logic       no_object;
	logic       overflow;
	int         errors;
	int         pending;
	int         vertices_seen;

	// idling is switched off for a long stretch in the middle
	bit         quiet;
	// toggled by the stimulus to ask the receiver for a long hold-off
	bit         hold_toggle;
	int         pixels_sent;

	binary_image_convex_hull_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.pixel_set(pixel_set), .out_valid(out_valid), .out_stall(out_stall),
		.hull_x(hull_x), .hull_y(hull_y), .last_vertex(last_vertex),
		.no_object(no_object), .overflow(overflow)
	);

	cvh_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.pixel_set(pixel_set), .out_valid(out_valid), .out_stall(out_stall),
		.hull_x(hull_x), .hull_y(hull_y), .last_vertex(last_vertex),
		.no_object(no_object), .overflow(overflow), .errors(errors),
		.pending(pending), .vertices_seen(vertices_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stalls, plus a long counted hold-off on request
	initial begin
		bit seen_toggle;
		int hold_left;
		seen_toggle = 1'b0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != seen_toggle) begin
				seen_toggle = hold_toggle;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= !quiet && ($urandom_range(99) < 8);
		end
	end

	// a pixel beat: optional idle gap, then hold valid until accepted
	task automatic send_pixel(logic set);
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_set <= set;
		do
			@(posedge clk);
		while (in_stall);
		pixels_sent++;
	endtask

	// wait until every expected vertex has arrived, then let the unit settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, cfg_reg_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(cfg_reg_t w, cfg_reg_t h);
		drain();
		write_reg(CFG_IDX_WIDTH, w);
		write_reg(CFG_IDX_HEIGHT, h);
	endtask

	function automatic int side_of(cfg_reg_t v);
		return (v == 0) ? 1 : (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
	endfunction

	// kinds of image content
	typedef enum int {IMG_EMPTY, IMG_FULL, IMG_NOISE, IMG_BLOB, IMG_SPARSE,
		IMG_ROW0} img_kind_t;

	// one whole image of the current size
	task automatic send_image(int w, int h, img_kind_t kind);
		int cx, cy, r, dens;
		logic set;
		cx = $urandom_range(w - 1);
		cy = $urandom_range(h - 1);
		r = $urandom_range(1, 4);
		dens = $urandom_range(5, 95);
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				case (kind)
					IMG_EMPTY: set = 1'b0;
					IMG_FULL: set = 1'b1;
					IMG_NOISE: set = $urandom_range(99) < dens;
					// a rough disc with ragged edges
					IMG_BLOB: set = ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r)
						&& ($urandom_range(9) != 0);
					IMG_SPARSE: set = $urandom_range(999) < 3;
					default: set = (y == 0) && $urandom_range(1);
				endcase
				send_pixel(set);
			end
		end
	endtask

	initial begin
		int w, h;
		cfg_reg_t wr, hr;
		img_kind_t kind;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IDX_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_set = 1'b0;
		quiet = 1'b0;
		hold_toggle = 1'b0;
		pixels_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-pixel images, empty and set, with zero sizes
		set_size(cfg_reg_t'(0), cfg_reg_t'(0));
		send_image(1, 1, IMG_EMPTY);
		send_image(1, 1, IMG_FULL);
		// a lone point in a small frame
		set_size(cfg_reg_t'(3), cfg_reg_t'(2));
		send_pixel(1'b0); send_pixel(1'b0); send_pixel(1'b0);
		send_pixel(1'b0); send_pixel(1'b1); send_pixel(1'b0);
		// full square: collinear edges
		set_size(cfg_reg_t'(3), cfg_reg_t'(3));
		send_image(3, 3, IMG_FULL);
		// object only in row 0, width clamped from the top of the register
		set_size(cfg_reg_t'(127), cfg_reg_t'(1));
		send_image(64, 1, IMG_ROW0);
		// one column, collinear points
		set_size(cfg_reg_t'(1), cfg_reg_t'(12));
		send_image(1, 12, IMG_NOISE);

		// random: mostly small blobs and noise of varied sizes
		set_size(cfg_reg_t'(5), cfg_reg_t'(5));
		w = 5;
		h = 5;
		for (int n = 0; pixels_sent < 210 || n < 6; n++) begin
			if (n % 3 == 0) begin
				wr = cfg_reg_t'($urandom_range(1, 9));
				hr = cfg_reg_t'($urandom_range(1, 9));
				if ($urandom_range(9) == 0)
					wr = cfg_reg_t'($urandom_range(127));
				if (wr * hr > 81)
					hr = cfg_reg_t'($urandom_range(1, 2));
				set_size(wr, hr);
				w = side_of(wr);
				h = side_of(hr);
			end
			// no idling for a stretch
			quiet = (n >= 2 && n < 5);
			// long receiver hold-off while images keep coming
			if (n == 1)
				hold_toggle = !hold_toggle;
			// sender pause until all vertices are out
			if (n == 4)
				drain();
			case ($urandom_range(9))
				0: kind = IMG_EMPTY;
				1: kind = IMG_FULL;
				2, 3, 4: kind = IMG_NOISE;
				9: kind = IMG_ROW0;
				default: kind = IMG_BLOB;
			endcase
			if (w * h > 200 && kind != IMG_EMPTY)
				kind = IMG_SPARSE;
			send_image(w, h, kind);
		end
		quiet = 1'b0;
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#40ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/cvh_pkg.sv
hw/rtl/cvh_mul.sv
hw/rtl/cvh_pmem.sv
hw/rtl/binary_image_convex_hull_unit.sv
bench/cvh_checker.sv
bench/testbench.sv
